// ===== src/htag_pkg.sv =====
// htag_pkg: shared types, character codes and match tables for the http request field tagger
package htag_pkg;

  localparam int unsigned NUM_METHODS = 7;
  localparam int unsigned PREFIX_LEN  = 4;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LOW_H = 8'h68;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // first character sits in the top byte
  localparam logic [31:0] METHOD_WORDS [NUM_METHODS] = '{
    "GET ", "POST", "PUT ", "HEAD", "DELE", "PATC", "OPTI"
  };
  localparam logic [31:0] HOST_WORD = "host";

  typedef enum logic [1:0] {
    LP_METHOD = 2'd0,
    LP_PATH   = 2'd1,
    LP_REST   = 2'd2,
    LP_DONE   = 2'd3
  } line_phase_t;

  typedef enum logic [1:0] {
    HP_SEARCH = 2'd0,
    HP_BLANKS = 2'd1,
    HP_VALUE  = 2'd2,
    HP_DONE   = 2'd3
  } host_phase_t;

  function automatic logic [7:0] method_char(input logic [2:0] m, input logic [1:0] idx);
    logic [31:0] w;
    w = METHOD_WORDS[m];
    return w[(5'd24 - {idx, 3'b000}) +: 8];
  endfunction

  function automatic logic [7:0] host_char(input logic [1:0] idx);
    return HOST_WORD[(5'd24 - {idx, 3'b000}) +: 8];
  endfunction

endpackage

// ===== src/http_request_field_tagger.sv =====
// http_request_field_tagger: top level, byte tagging pipeline for method, path and host fields
//
// Takes one payload byte per cycle while in_stall is low and returns it one-for-one, tagged
// as part of the request method, the path or the Host header value. Throughput is one byte
// per cycle while out_stall is low; a byte passes through an input register, the tag logic
// and a result register, and its result is presented on the outputs from that register.
// The verdicts (accepted, path_closed, host_seen) are valid only on the result that
// carries end_mark; that byte also returns the parser to its reset state, so the next
// byte starts a new payload. Tags are raw and should be kept only when accepted is set.
module http_request_field_tagger
  import htag_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out,
  output logic       out_in_method,
  output logic       out_in_path,
  output logic       out_in_host,
  output logic       out_end_mark,
  output logic       out_accepted,
  output logic       out_path_closed,
  output logic       out_host_seen
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // result register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_method_r, out_path_r, out_host_r, out_end_r;
  logic       out_acc_r, out_pclosed_r, out_hseen_r;

  // parser state
  logic [2:0]  prefix_cnt_r, prefix_cnt_nxt;
  logic [6:0]  cand_r, cand_nxt;
  line_phase_t line_r, line_nxt;
  logic        method_closed_r, method_closed_nxt;
  logic        second_space_r, second_space_nxt;
  logic [2:0]  host_prog_r, host_prog_nxt;
  host_phase_t host_r, host_nxt;
  logic        host_commit_r, host_commit_nxt;

  logic       adv;
  logic       in_xfer;
  logic       eol, blank;
  logic [7:0] lower;
  logic       t_method, t_path, t_host;
  logic       v_acc, v_pclosed, v_hseen;

  assign adv     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer = in_valid && !in_stall;

  assign eol   = (s1_byte_r == CH_CR) || (s1_byte_r == CH_LF);
  assign blank = (s1_byte_r == CH_SPACE) || (s1_byte_r == CH_TAB);
  assign lower = s1_byte_r | CASE_BIT;

  always_comb begin
    prefix_cnt_nxt    = prefix_cnt_r;
    cand_nxt          = cand_r;
    line_nxt          = line_r;
    method_closed_nxt = method_closed_r;
    second_space_nxt  = second_space_r;
    host_prog_nxt     = host_prog_r;
    host_nxt          = host_r;
    host_commit_nxt   = host_commit_r;
    t_method          = 1'b0;
    t_path            = 1'b0;
    t_host            = 1'b0;

    // method prefix, one position per byte
    if (!prefix_cnt_r[2]) begin
      for (int m = 0; m < NUM_METHODS; m++) begin
        if (method_char(3'(m), prefix_cnt_r[1:0]) != s1_byte_r) cand_nxt[m] = 1'b0;
      end
      prefix_cnt_nxt = prefix_cnt_r + 3'd1;
    end

    // first line
    unique case (line_r) inside
      LP_METHOD, LP_PATH, LP_REST: begin
        if (eol) begin
          line_nxt = LP_DONE;
        end else if (s1_byte_r == CH_SPACE) begin
          if (line_r == LP_METHOD) begin
            method_closed_nxt = 1'b1;
            line_nxt          = LP_PATH;
          end else if (line_r == LP_PATH) begin
            second_space_nxt = 1'b1;
            line_nxt         = LP_REST;
          end
        end else begin
          t_method = (line_r == LP_METHOD);
          t_path   = (line_r == LP_PATH);
        end
      end
      LP_DONE: ;
      default: ;
    endcase

    // host header search
    unique case (host_r)
      HP_SEARCH: begin
        if (host_prog_r[2]) begin
          if (s1_byte_r == CH_COLON) begin
            host_nxt      = HP_BLANKS;
            host_prog_nxt = 3'd0;
          end else begin
            host_prog_nxt = {2'b00, lower == CH_LOW_H};
          end
        end else if (lower == host_char(host_prog_r[1:0])) begin
          host_prog_nxt = host_prog_r + 3'd1;
        end else begin
          host_prog_nxt = {2'b00, lower == CH_LOW_H};
        end
      end
      HP_BLANKS: begin
        if (eol) begin
          host_nxt      = HP_SEARCH;
          host_prog_nxt = 3'd0;
        end else if (!blank) begin
          host_commit_nxt = 1'b1;
          if (s1_byte_r == CH_COLON) begin
            host_nxt = HP_DONE;
          end else begin
            host_nxt = HP_VALUE;
            t_host   = 1'b1;
          end
        end
      end
      HP_VALUE: begin
        if (eol || s1_byte_r == CH_COLON) host_nxt = HP_DONE;
        else t_host = 1'b1;
      end
      HP_DONE: ;
      default: ;
    endcase

    // verdicts see this byte's updates
    v_acc     = 1'b0;
    v_pclosed = 1'b0;
    v_hseen   = 1'b0;
    if (s1_last_r) begin
      v_acc     = prefix_cnt_nxt[2] && (|cand_nxt) && method_closed_nxt;
      v_pclosed = second_space_nxt;
      v_hseen   = host_commit_nxt;
      prefix_cnt_nxt    = 3'd0;
      cand_nxt          = '1;
      line_nxt          = LP_METHOD;
      method_closed_nxt = 1'b0;
      second_space_nxt  = 1'b0;
      host_prog_nxt     = 3'd0;
      host_nxt          = HP_SEARCH;
      host_commit_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_cnt_r    <= 3'd0;
      cand_r          <= '1;
      line_r          <= LP_METHOD;
      method_closed_r <= 1'b0;
      second_space_r  <= 1'b0;
      host_prog_r     <= 3'd0;
      host_r          <= HP_SEARCH;
      host_commit_r   <= 1'b0;
    end else if (adv) begin
      prefix_cnt_r    <= prefix_cnt_nxt;
      cand_r          <= cand_nxt;
      line_r          <= line_nxt;
      method_closed_r <= method_closed_nxt;
      second_space_r  <= second_space_nxt;
      host_prog_r     <= host_prog_nxt;
      host_r          <= host_nxt;
      host_commit_r   <= host_commit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;
      if (adv) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_is_last;
    end
    if (adv) begin
      out_byte_r    <= s1_byte_r;
      out_method_r  <= t_method;
      out_path_r    <= t_path;
      out_host_r    <= t_host;
      out_end_r     <= s1_last_r;
      out_acc_r     <= v_acc;
      out_pclosed_r <= v_pclosed;
      out_hseen_r   <= v_hseen;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_out    = out_byte_r;
  assign out_in_method   = out_method_r;
  assign out_in_path     = out_path_r;
  assign out_in_host     = out_host_r;
  assign out_end_mark    = out_end_r;
  assign out_accepted    = out_acc_r;
  assign out_path_closed = out_pclosed_r;
  assign out_host_seen   = out_hseen_r;

`ifndef SYNTHESIS
  a_verdict_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_mark |-> !out_accepted && !out_path_closed && !out_host_seen)
    else $error("verdict set on a result without end mark");

  a_method_path_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_in_method && out_in_path))
    else $error("byte tagged as both method and path");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_last_r |=> prefix_cnt_r == 3'd0 && host_r == HP_SEARCH && line_r == LP_METHOD)
    else $error("parser state not cleared after final byte");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  a_host_tag_phase: assert property (@(posedge clk) disable iff (!rst_n)
    adv && t_host |-> host_r == HP_BLANKS || host_r == HP_VALUE)
    else $error("host tag outside host value");
`endif

endmodule
